// File: src/start_lamp_sequencer_macros.svh
// ----------------------------------------------------------------------------
// start_lamp_sequencer_macros.svh
// Assertion macros shared by the start lamp sequencer checker.
// ----------------------------------------------------------------------------
`ifndef START_LAMP_SEQUENCER_MACROS_SVH
`define START_LAMP_SEQUENCER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLSEQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("start lamp sequencer assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SLSEQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("start lamp sequencer assertion failed");

`endif

// File: src/slseq_pkg.sv
// ----------------------------------------------------------------------------
// slseq_pkg
// Types, register indexes and reset values for the start lamp sequencer.
// ----------------------------------------------------------------------------
package slseq_pkg;

    localparam int unsigned TIME_W      = 16;
    localparam int unsigned CFG_INDEX_W = 4;

    typedef logic [TIME_W-1:0]      ms_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    // Configuration register indexes.
    localparam cfg_index_t CFG_GREEN_HOLD = cfg_index_t'(0);
    localparam cfg_index_t CFG_GREEN_LEAD = cfg_index_t'(1);
    localparam cfg_index_t CFG_BUZZER     = cfg_index_t'(2);
    localparam cfg_index_t CFG_DEBOUNCE   = cfg_index_t'(3);

    // Reset values of the configuration registers.
    localparam ms_t GREEN_HOLD_RESET = ms_t'(2000);
    localparam ms_t GREEN_LEAD_RESET = ms_t'(50);
    localparam ms_t BUZZER_RESET     = ms_t'(500);
    localparam ms_t DEBOUNCE_RESET   = ms_t'(20);

    localparam ms_t SINCE_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RED   = 2'd1,
        OP_GREEN = 2'd2,
        OP_RESET = 2'd3
    } op_t;

    typedef struct packed {
        op_t  op;
        logic button_pressed;
    } in_t;

    typedef struct packed {
        logic red_lamp;
        logic green_lamp;
        logic buzzer_drive;
        logic button_event;
    } out_t;

    typedef struct packed {
        ms_t hold_time;
        ms_t lead_time;
        ms_t buzz_time;
        ms_t settle_time;
    } cfg_t;

    typedef struct packed {
        logic red_state;
        logic green_state;
        logic buzz_state;
        ms_t  green_left;
        ms_t  red_left;
        ms_t  buzz_left;
        logic button_level;
        ms_t  since_change;
    } state_t;

endpackage

// File: src/start_lamp_sequencer.sv
// ----------------------------------------------------------------------------
// start_lamp_sequencer
// Start-signal lamp controller: red, green and buzzer driven by ticks and commands.
// ----------------------------------------------------------------------------
// A word's result is registered on out_data in the cycle after it is accepted.
// Throughput: one word per cycle while out_stall is low; the state update is a single
// pass of countdown and compare logic between state registers and result register.
// Reset: rst_n clears lamps, buzzer, countdowns, debounce state and the result
// register at once, and loads the configuration registers with their defaults.
module start_lamp_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  slseq_pkg::in_t         in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output slseq_pkg::out_t        out_data,
    input  logic                   cfg_we,
    input  slseq_pkg::cfg_index_t  cfg_index,
    input  slseq_pkg::ms_t         cfg_data
);
    import slseq_pkg::*;

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    out_t   result_next;
    out_t   out_data_reg;
    logic   out_valid_reg;
    logic   in_accept;

    // The result register frees up in the same cycle that its word is taken, so
    // a new word can be accepted every cycle while the output side keeps up.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    // Configuration writes; an index beyond the four registers is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time   <= GREEN_HOLD_RESET;
            cfg_reg.lead_time   <= GREEN_LEAD_RESET;
            cfg_reg.buzz_time   <= BUZZER_RESET;
            cfg_reg.settle_time <= DEBOUNCE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GREEN_HOLD: cfg_reg.hold_time   <= cfg_data;
                CFG_GREEN_LEAD: cfg_reg.lead_time   <= cfg_data;
                CFG_BUZZER:     cfg_reg.buzz_time   <= cfg_data;
                CFG_DEBOUNCE:   cfg_reg.settle_time <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    slseq_step u_step (
        .cur    (state_reg),
        .cfg    (cfg_reg),
        .item   (in_data),
        .nxt    (state_next),
        .result (result_next)
    );

    // The state moves on as each word is accepted, and its result is captured
    // alongside it so the output side sees the lamp drive after that word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                state_reg     <= state_next;
                out_data_reg  <= result_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/slseq_step.sv
// ----------------------------------------------------------------------------
// slseq_step
// Next-state and result logic for one tick or command.
// ----------------------------------------------------------------------------
module slseq_step (
    input  slseq_pkg::state_t cur,
    input  slseq_pkg::cfg_t   cfg,
    input  slseq_pkg::in_t    item,
    output slseq_pkg::state_t nxt,
    output slseq_pkg::out_t   result
);
    import slseq_pkg::*;

    ms_t  green_dec;
    ms_t  red_dec;
    ms_t  buzz_dec;
    ms_t  since_inc;
    logic accept_change;
    logic press;

    // A countdown at zero stays there; one at one expires on this tick.
    assign green_dec = (cur.green_left != '0) ? cur.green_left - ms_t'(1) : '0;
    assign red_dec   = (cur.red_left   != '0) ? cur.red_left   - ms_t'(1) : '0;
    assign buzz_dec  = (cur.buzz_left  != '0) ? cur.buzz_left  - ms_t'(1) : '0;

    assign since_inc = (cur.since_change != SINCE_MAX) ? cur.since_change + ms_t'(1)
                                                       : cur.since_change;
    assign accept_change = (item.button_pressed != cur.button_level)
                        && (since_inc > cfg.settle_time);
    assign press = accept_change && item.button_pressed;

    always_comb
    begin
        nxt = cur;
        result.button_event = 1'b0;
        unique case (item.op)
            OP_TICK:
            begin
                nxt.green_left = green_dec;
                nxt.red_left   = red_dec;
                nxt.buzz_left  = buzz_dec;
                if (cur.green_left == ms_t'(1))
                begin
                    nxt.green_state = 1'b0;
                end
                if (cur.red_left == ms_t'(1))
                begin
                    nxt.red_state = 1'b0;
                end
                if (cur.buzz_left == ms_t'(1))
                begin
                    nxt.buzz_state = 1'b0;
                end
                nxt.since_change = since_inc;
                if (accept_change)
                begin
                    nxt.button_level = item.button_pressed;
                    nxt.since_change = '0;
                end
                result.button_event = press;
            end
            OP_RED:
            begin
                nxt.red_state   = 1'b1;
                nxt.green_state = 1'b0;
                nxt.green_left  = '0;
                nxt.red_left    = '0;
            end
            OP_GREEN:
            begin
            end
            OP_RESET:
            begin
                nxt.red_state   = 1'b0;
                nxt.green_state = 1'b0;
                nxt.buzz_state  = 1'b0;
                nxt.green_left  = '0;
                nxt.red_left    = '0;
                nxt.buzz_left   = '0;
            end
            default:
            begin
            end
        endcase

        // A green command or an accepted press lights green, sounds the buzzer and reloads the timers.
        if (item.op == OP_GREEN || (item.op == OP_TICK && press))
        begin
            nxt.green_state = 1'b1;
            nxt.buzz_state  = 1'b1;
            nxt.red_left    = (cfg.lead_time == '0) ? ms_t'(1) : cfg.lead_time;
            nxt.green_left  = (cfg.hold_time == '0) ? ms_t'(1) : cfg.hold_time;
            nxt.buzz_left   = (cfg.buzz_time == '0) ? ms_t'(1) : cfg.buzz_time;
        end

        result.red_lamp     = nxt.red_state;
        result.green_lamp   = nxt.green_state;
        result.buzzer_drive = nxt.buzz_state;
    end

endmodule

// File: src/slseq_checker.sv
// ----------------------------------------------------------------------------
// slseq_checker
// Port-level assertions for the start lamp sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`include "start_lamp_sequencer_macros.svh"

module slseq_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input slseq_pkg::in_t        in_data,
    input logic                  out_valid,
    input logic                  out_stall,
    input slseq_pkg::out_t       out_data
);
    import slseq_pkg::*;

    // A held result keeps its value.
    `SLSEQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // An accepted press always lights green and sounds the buzzer.
    `SLSEQ_ASSERT_NOW(a_press_lights, out_valid && out_data.button_event,
                      out_data.green_lamp && out_data.buzzer_drive)

    // A reset command darkens everything in its result.
    `SLSEQ_ASSERT_NEXT(a_reset_cmd, in_valid && !in_stall && in_data.op == OP_RESET,
                       out_valid && out_data == '0)

    // A red command lights red and darkens green.
    `SLSEQ_ASSERT_NEXT(a_red_cmd, in_valid && !in_stall && in_data.op == OP_RED,
                       out_valid && out_data.red_lamp && !out_data.green_lamp)

endmodule

bind start_lamp_sequencer slseq_checker u_slseq_checker (.*);
